// ===== sv/isc_pkg.sv =====
// Shared types and constants for the iterated SHA-256 checkpoint chain.
`timescale 1ns / 1ps
package isc_pkg;

  localparam int unsigned RegRounds = 0;
  localparam int unsigned RegCount  = 1;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;

  // one queued request between the front and the back end
  typedef struct packed {
    logic         op;
    logic [255:0] start;
    logic [255:0] expect_v;
    logic [31:0]  rounds;
    logic [6:0]   count;
  } req_t;

  localparam logic [255:0] HInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] kround(input logic [5:0] i);
    logic [31:0] k;
    begin
      unique case (i)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== sv/isc_front.sv =====
// Front end: captures requests with the configuration snapshot into a small queue.
`timescale 1ns / 1ps
module isc_front #(
  parameter int unsigned MAX_CHECKPOINTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [255:0]      in_start,
  input  logic [255:0]      in_expect,
  input  logic [31:0]       rounds,
  input  logic [6:0]        count,
  output logic              q_valid,
  input  logic              q_take,
  output isc_pkg::req_t     q_req
);
  isc_pkg::req_t q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    fill_r;
  logic [6:0]    cnt_eff;
  logic          push;

  // count clamped to 1..MAX_CHECKPOINTS; check ops use a single result
  always_comb begin
    if (count == 7'd0) cnt_eff = 7'd1;
    else if (count > 7'(MAX_CHECKPOINTS)) cnt_eff = 7'(MAX_CHECKPOINTS);
    else cnt_eff = count;
    if (in_op) cnt_eff = 7'd1;
  end

  assign in_stall = fill_r[1];
  assign push     = in_valid && !in_stall;
  assign q_valid  = fill_r != 2'd0;
  assign q_req    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{op: in_op, start: in_start, expect_v: in_expect,
                     rounds: rounds, count: cnt_eff};
    end
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; fill_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_take) rp_r <= !rp_r;
      fill_r <= fill_r + 2'(push) - 2'(q_take);
    end
  end
endmodule

// ===== sv/isc_back.sv =====
// Back end: iterative SHA-256 engine, one round per cycle, with an output register.
`timescale 1ns / 1ps
module isc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_take,
  input  isc_pkg::req_t     q_req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [255:0]      out_digest,
  output logic [6:0]        out_index,
  output logic              out_match,
  output logic              out_last
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_HASH = 4'b0010, S_FIN = 4'b0100, S_EMIT = 4'b1000
  } state_t;

  state_t        st_r;
  isc_pkg::req_t req_r;
  logic [255:0]  v_r;
  logic [31:0]   a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0]   w_r [16];
  logic [5:0]    rnd_r;
  logic [31:0]   hcnt_r;
  logic [6:0]    k_r;
  logic          ov_r;

  logic [31:0] t1, t2, wn, wcur;

  always_comb begin
    wcur = w_r[0];
    t1 = h_r + (isc_pkg::rotr(e_r, 6) ^ isc_pkg::rotr(e_r, 11) ^ isc_pkg::rotr(e_r, 25))
         + ((e_r & f_r) ^ (~e_r & g_r)) + isc_pkg::kround(rnd_r) + wcur;
    t2 = (isc_pkg::rotr(a_r, 2) ^ isc_pkg::rotr(a_r, 13) ^ isc_pkg::rotr(a_r, 22))
         + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
    wn = w_r[0]
         + (isc_pkg::rotr(w_r[1], 7) ^ isc_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3))
         + w_r[9]
         + (isc_pkg::rotr(w_r[14], 17) ^ isc_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10));
  end

  assign q_take     = (st_r == S_IDLE) && q_valid;
  assign out_valid  = ov_r;
  assign out_digest = v_r;
  assign out_index  = k_r;
  assign out_match  = req_r.op && (v_r == req_r.expect_v);
  assign out_last   = k_r == req_r.count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            req_r  <= q_req;
            v_r    <= q_req.start;
            hcnt_r <= q_req.rounds;
            k_r    <= 7'd1;
            st_r   <= S_FIN;
          end
        end
        // decide whether another hash is due for this checkpoint
        S_FIN: begin
          if (hcnt_r == 32'd0) begin
            ov_r <= 1'b1;
            st_r <= S_EMIT;
          end else begin
            hcnt_r <= hcnt_r - 32'd1;
            for (int i = 0; i < 8; i++) w_r[i] <= v_r[255 - 32*i -: 32];
            w_r[8] <= 32'h80000000;
            for (int i = 9; i < 15; i++) w_r[i] <= 32'd0;
            w_r[15] <= 32'd256;
            {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= isc_pkg::HInit;
            rnd_r <= 6'd0;
            st_r  <= S_HASH;
          end
        end
        S_HASH: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wn;
          h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
          d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            v_r <= {isc_pkg::HInit[255:224] + (t1 + t2), isc_pkg::HInit[223:192] + a_r,
                    isc_pkg::HInit[191:160] + b_r, isc_pkg::HInit[159:128] + c_r,
                    isc_pkg::HInit[127:96] + (d_r + t1), isc_pkg::HInit[95:64] + e_r,
                    isc_pkg::HInit[63:32] + f_r, isc_pkg::HInit[31:0] + g_r};
            st_r <= S_FIN;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            ov_r <= 1'b0;
            if (out_last) begin
              st_r <= S_IDLE;
            end else begin
              k_r    <= k_r + 7'd1;
              hcnt_r <= req_r.rounds;
              st_r   <= S_FIN;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/iterated_sha256_checkpoint_chain.sv =====
// Top level of the iterated SHA-256 checkpoint chain.
// Usage:
//   Input channel (in_valid/in_stall): op 0 solves from the seed in
//   in_start_w0..3 and returns checkpoint_count checkpoints; op 1 hashes the
//   start value rounds_per_checkpoint times and compares with in_expect_w0..3.
//   Output channel (out_valid/out_stall): one transaction per checkpoint,
//   out_last marks the final one for a request.
//   Configuration: cfg_we/cfg_idx/cfg_data, written by the user while the block is idle (not enforced).
// Engine: each SHA-256 runs its 64 rounds on the single round unit after a
//   setup step in S_FIN; a checkpoint chains rounds_per_checkpoint hashes, and
//   the default is a single round and a single checkpoint per request.
//   A two-entry request queue lets new requests be accepted while the hash
//   engine works; one request is hashed at a time.
// Reset: registers return to rounds 1, count 1; queue and engine empty.
// Stall: a stalled result holds on the output register and the engine waits.
`timescale 1ns / 1ps
module iterated_sha256_checkpoint_chain #(
  parameter int unsigned MAX_CHECKPOINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [isc_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [isc_pkg::CfgDataW-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [63:0] in_start_w0,
  input  logic [63:0] in_start_w1,
  input  logic [63:0] in_start_w2,
  input  logic [63:0] in_start_w3,
  input  logic [63:0] in_expect_w0,
  input  logic [63:0] in_expect_w1,
  input  logic [63:0] in_expect_w2,
  input  logic [63:0] in_expect_w3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_w0,
  output logic [63:0] out_digest_w1,
  output logic [63:0] out_digest_w2,
  output logic [63:0] out_digest_w3,
  output logic [6:0]  out_checkpoint_index,
  output logic        out_match,
  output logic        out_last
);
  logic [31:0]   rounds_r;
  logic [6:0]    count_r;
  logic          q_valid, q_take;
  isc_pkg::req_t q_req;
  logic [255:0]  digest;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_r <= 32'd1;
      count_r  <= 7'd1;
    end else if (cfg_we) begin
      unique case (32'(cfg_idx))
        isc_pkg::RegRounds: rounds_r <= cfg_data;
        isc_pkg::RegCount:  count_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  isc_front #(.MAX_CHECKPOINTS(MAX_CHECKPOINTS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_op,
    .in_start({in_start_w0, in_start_w1, in_start_w2, in_start_w3}),
    .in_expect({in_expect_w0, in_expect_w1, in_expect_w2, in_expect_w3}),
    .rounds(rounds_r), .count(count_r),
    .q_valid, .q_take, .q_req
  );

  isc_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_req,
    .out_valid, .out_stall, .out_digest(digest),
    .out_index(out_checkpoint_index), .out_match, .out_last
  );

  assign {out_digest_w0, out_digest_w1, out_digest_w2, out_digest_w3} = digest;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_checkpoint_index != 7'd0 &&
                   out_checkpoint_index <= 7'(MAX_CHECKPOINTS)))
    else $error("checkpoint index out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(digest))
    else $error("stalled result changed");
  a_match_solve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match |-> out_last && out_checkpoint_index == 7'd1)
    else $error("match outside check result");
endmodule
